### sv/clnw_pkg.sv
// Shared types, constants and power-up tables for the character LCD nibble writer.
package clnw_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;

  // Operation codes carried in the input kind field
  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_BUDGET  = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_NIBBLE_SETTLE = 2'd0;
  localparam logic [1:0] CFG_BYTE_SETTLE   = 2'd1;

  localparam logic [7:0] NIBBLE_SETTLE_RST = 8'd50;
  localparam logic [9:0] BYTE_SETTLE_RST   = 10'd100;

  // Sequencer steps
  localparam logic [4:0] STEP_POWER_UP   = 5'd0;
  localparam logic [4:0] STEP_LAST_NIB   = 5'd8;
  localparam logic [4:0] STEP_INIT_BYTES = 5'd9;
  localparam logic [4:0] STEP_USER_BYTES = 5'd17;
  localparam logic [4:0] STEP_IDLE       = 5'd25;

  localparam logic [15:0] POWER_WAIT = 16'd50000;
  localparam logic [15:0] FINAL_WAIT = 16'd2000;
  localparam logic [8:0]  FIRST_INIT_BYTE = 9'h028;

  // Pin level vector: bit0 RS, bit1 E, bits 5:2 D4..D7
  localparam int PIN_RS = 0;
  localparam int PIN_E  = 1;

  typedef struct packed {
    logic [4:0]  step;
    logic [15:0] wait_cnt;
    logic [8:0]  cur;
    logic [5:0]  pins;
  } seq_state_t;

  function automatic logic [3:0] power_nibble(input logic [1:0] k);
    power_nibble = (k == 2'd3) ? 4'h2 : 4'h3;
  endfunction

  function automatic logic [15:0] power_wait(input logic [1:0] k);
    power_wait = (k == 2'd0) ? 16'd5000 : 16'd1000;
  endfunction

  // Next byte of the power-up command list; zero ends the list
  function automatic logic [7:0] next_power_byte(input logic [7:0] b);
    unique case (b)
      8'h28:   next_power_byte = 8'h0C;
      8'h0C:   next_power_byte = 8'h06;
      8'h06:   next_power_byte = 8'h01;
      default: next_power_byte = 8'h00;
    endcase
  endfunction

endpackage

### sv/clnw_seq.sv
// Pin sequencer: next timing, step, byte and pin state for one microsecond tick.
module clnw_seq
  import clnw_pkg::*;
(
  input  logic       tick,
  input  seq_state_t st,
  input  logic       can_pop,
  input  logic [8:0] head,
  input  logic [7:0] nib_settle,
  input  logic [9:0] byte_settle,
  output seq_state_t nxt,
  output logic       pop
);

  logic [15:0] w;
  logic [15:0] nib_w;
  logic        do_phase;
  logic [4:0]  ph_s;
  logic [8:0]  ph_cur;
  logic        init;
  logic [4:0]  ph_off;
  logic [2:0]  p;
  logic [1:0]  k;
  logic [4:0]  s_m1;
  logic [7:0]  nb;

  always_comb begin
    nxt      = st;
    pop      = 1'b0;
    do_phase = 1'b0;
    nib_w    = 16'(nib_settle);
    w        = st.wait_cnt - {15'd0, (st.wait_cnt != 16'd0)};
    s_m1     = st.step - 5'd1;
    k        = s_m1[2:1];
    if (tick) begin
      nxt.wait_cnt = w;
    end
    if (tick && (w == 16'd0)) begin
      priority if (st.step == STEP_POWER_UP) begin
        nxt.pins     = '0;
        nxt.wait_cnt = POWER_WAIT;
        nxt.step     = 5'd1;
      end else if (st.step < STEP_INIT_BYTES) begin
        if (!s_m1[0]) begin
          nxt.pins     = {power_nibble(k), 1'b1, 1'b0};
          nxt.wait_cnt = 16'd1;
        end else begin
          nxt.pins[PIN_E] = 1'b0;
          nxt.wait_cnt    = nib_w + power_wait(k);
        end
        if (st.step == STEP_LAST_NIB) begin
          nxt.cur = FIRST_INIT_BYTE;
        end
        nxt.step = st.step + 5'd1;
      end else if (st.step < STEP_IDLE || can_pop) begin
        do_phase = 1'b1;
      end else begin
        nxt.step = STEP_IDLE;
      end
    end

    // One byte phase; an idle sequencer pops the queue head and starts a byte
    pop    = do_phase && (st.step >= STEP_IDLE);
    ph_s   = pop ? STEP_USER_BYTES : st.step;
    ph_cur = pop ? head : st.cur;
    init   = ph_s < STEP_USER_BYTES;
    ph_off = ph_s - (init ? STEP_INIT_BYTES : STEP_USER_BYTES);
    p      = ph_off[2:0];
    nb     = next_power_byte(ph_cur[7:0]);
    if (do_phase) begin
      nxt.cur  = ph_cur;
      nxt.step = ph_s + 5'd1;
      unique case (p)
        3'd0, 3'd4: begin
          nxt.pins[PIN_RS] = ph_cur[8];
          nxt.wait_cnt     = 16'd1;
        end
        3'd1: begin
          nxt.pins[5:2] = ph_cur[7:4];
          nxt.wait_cnt  = 16'd1;
        end
        3'd5: begin
          nxt.pins[5:2] = ph_cur[3:0];
          nxt.wait_cnt  = 16'd1;
        end
        3'd2, 3'd6: begin
          nxt.pins[PIN_E] = 1'b1;
          nxt.wait_cnt    = 16'd1;
        end
        3'd3: begin
          nxt.pins[PIN_E] = 1'b0;
          nxt.wait_cnt    = nib_w;
        end
        default: begin
          nxt.pins[PIN_E] = 1'b0;
          nxt.wait_cnt    = nib_w + 16'(byte_settle);
          nxt.step        = STEP_IDLE;
          if (init) begin
            if (nb == 8'h00) begin
              nxt.wait_cnt = nib_w + 16'(byte_settle) + FINAL_WAIT;
            end else begin
              nxt.cur  = {1'b0, nb};
              nxt.step = STEP_INIT_BYTES;
            end
          end
        end
      endcase
    end
  end

endmodule

### sv/char_lcd_nibble_writer_fifo_unit.sv
// Top level: character LCD 4-bit writer fed from a byte queue in block memory.
//
// Channel | Direction | Handshake           | Payload
// in_     | in        | in_tvalid/in_tready | tdata byte_value,budget; tuser operation,is_data
// out_    | out       | out_tvalid/out_tready | tdata pins, queue level, status flags
// cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data (always ready)
//
// Each transaction is accepted in ST_IDLE, which reads the queue head from the
// synchronous memory; ST_EXEC then does the read-modify-write of all state
// and loads the output register. One result per input transaction.
// A stalled output holds in its register and blocks the next input accept.
// rst_n is synchronous, active low; the queue memory is not cleared.
module char_lcd_nibble_writer_fifo_unit
  import clnw_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] byte_value, [15:8] budget
  input  logic [2:0]  in_tuser,   // [1:0] operation, [2] is_data
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] pin_rs, [1] pin_enable, [5:2] pin_data,
                                  // [12:6] queue_level, [13] dropped,
                                  // [14] busy_res, [15] init_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  // Queue storage: bit 8 is the data/command flag
  logic [8:0] queue_mem [QUEUE_DEPTH];
  logic [8:0] head_r;

  logic             state_r, state_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       budget_r, budget_nxt;
  seq_state_t       seq_r, seq_nxt;
  logic [7:0]       nib_settle_r;
  logic [9:0]       byte_settle_r;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic [15:0]      out_tdata_r, out_tdata_nxt;

  // Captured transaction payload
  logic [1:0] op_r;
  logic [7:0] byte_r;
  logic       isd_r;
  logic [7:0] bud_in_r;

  logic       in_fire;
  logic       exec;
  logic       tick;
  logic       pop;
  logic       dropped;
  logic       full;
  seq_state_t seq_tick;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE) && (!out_tvalid_r || out_tready);
  assign in_fire    = in_tvalid && in_tready;
  assign exec       = (state_r == ST_EXEC);
  assign tick       = exec && (op_r == OP_TICK);
  assign full       = (cnt_r == CNT_FULL);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  clnw_seq u_seq (
    .tick        (tick),
    .st          (seq_r),
    .can_pop     ((budget_r != 8'd0) && (cnt_r != '0)),
    .head        (head_r),
    .nib_settle  (nib_settle_r),
    .byte_settle (byte_settle_r),
    .nxt         (seq_tick),
    .pop         (pop)
  );

  // Read-modify-write of queue control, budget and sequencer state
  always_comb begin
    state_nxt      = state_r;
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    cnt_nxt        = cnt_r;
    budget_nxt     = budget_r;
    seq_nxt        = seq_r;
    dropped        = 1'b0;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    if (in_fire) begin
      state_nxt = ST_EXEC;
    end
    if (exec) begin
      state_nxt = ST_IDLE;
      unique case (op_r)
        OP_ENQUEUE: begin
          // Full queue: drop the oldest entry, count stays at depth
          wr_ptr_nxt = ptr_inc(wr_ptr_r);
          if (full) begin
            rd_ptr_nxt = ptr_inc(rd_ptr_r);
            dropped    = 1'b1;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        OP_BUDGET: begin
          budget_nxt = bud_in_r;
        end
        OP_TICK: begin
          seq_nxt = seq_tick;
          if (pop) begin
            rd_ptr_nxt = ptr_inc(rd_ptr_r);
            cnt_nxt    = cnt_r - CNT_W'(1);
            budget_nxt = budget_r - 8'd1;
          end
        end
        default: ;
      endcase
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {(seq_nxt.step >= STEP_USER_BYTES),
                        ((seq_nxt.step < STEP_IDLE) || (seq_nxt.wait_cnt != 16'd0)),
                        dropped,
                        7'(cnt_nxt),
                        seq_nxt.pins};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      rd_ptr_r      <= '0;
      wr_ptr_r      <= '0;
      cnt_r         <= '0;
      budget_r      <= '0;
      seq_r         <= '0;
      nib_settle_r  <= NIBBLE_SETTLE_RST;
      byte_settle_r <= BYTE_SETTLE_RST;
      out_tvalid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      cnt_r        <= cnt_nxt;
      budget_r     <= budget_nxt;
      seq_r        <= seq_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_valid) begin
        if (cfg_index == CFG_NIBBLE_SETTLE) begin
          nib_settle_r <= cfg_data[7:0];
        end else if (cfg_index == CFG_BYTE_SETTLE) begin
          byte_settle_r <= cfg_data;
        end
      end
    end
  end

  // Payload registers: capture the transaction, hold the result
  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    if (in_fire) begin
      op_r     <= in_tuser[1:0];
      isd_r    <= in_tuser[2];
      byte_r   <= in_tdata[7:0];
      bud_in_r <= in_tdata[15:8];
    end
  end

  // Queue memory: head read on accept, entry write in the execute cycle
  always_ff @(posedge clk) begin
    if (in_fire) begin
      head_r <= queue_mem[rd_ptr_r];
    end
    if (exec && (op_r == OP_ENQUEUE)) begin
      queue_mem[wr_ptr_r] <= {isd_r, byte_r};
    end
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("queue count beyond depth");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_EXEC))
    else $error("accepted transaction not executed");

  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> out_tvalid_r)
    else $error("execute cycle produced no result");

  a_enable_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r.pins[PIN_E] |-> (seq_r.wait_cnt == 16'd1))
    else $error("enable high without a one-tick wait");

endmodule

### test/testbench.sv
// Self-checking testbench for the character LCD nibble writer: directed and random items.
module testbench
  import clnw_pkg::*;
();

  // The fourth operation code is unused by the block; it only reports status
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Predicts the pin levels, queue level and status flags for every accepted
  // transaction, and checks each returned result against the oldest prediction.
  class lcd_scoreboard;
    logic [8:0]  fifo_mem [QUEUE_DEPTH_DEF];
    int unsigned rd_ptr, wr_ptr, level;
    logic [7:0]  budget_left;
    logic [15:0] tick_wait;
    logic [4:0]  step;
    logic [8:0]  cur_byte;
    logic [5:0]  pins;
    logic [7:0]  nib_settle;
    logic [9:0]  byte_settle;
    logic [15:0] expected_q [$];
    int          errors;

    function new();
      rd_ptr      = 0;
      wr_ptr      = 0;
      level       = 0;
      budget_left = '0;
      tick_wait   = '0;
      step        = STEP_POWER_UP;
      cur_byte    = '0;
      pins        = '0;
      nib_settle  = NIBBLE_SETTLE_RST;
      byte_settle = BYTE_SETTLE_RST;
      errors      = 0;
    endfunction

    function void set_config(logic [1:0] idx, logic [9:0] val);
      case (idx)
        CFG_NIBBLE_SETTLE: nib_settle = val[7:0];
        CFG_BYTE_SETTLE:   byte_settle = val;
        default: ;
      endcase
    endfunction

    function bit init_seen();
      return step >= STEP_USER_BYTES;
    endfunction

    // One pin action of a byte transfer: two nibbles, high first
    function void byte_phase(logic [4:0] s);
      bit         init_bytes;
      logic [2:0] ph;
      logic [7:0] next_cmd;
      init_bytes = (s < STEP_USER_BYTES);
      ph = init_bytes ? 3'(s - STEP_INIT_BYTES) : 3'(s - STEP_USER_BYTES);
      step = s + 5'd1;
      case (ph)
        3'd0, 3'd4: begin
          pins[PIN_RS] = cur_byte[8];
          tick_wait = 16'd1;
        end
        3'd1: begin
          pins[5:2] = cur_byte[7:4];
          tick_wait = 16'd1;
        end
        3'd5: begin
          pins[5:2] = cur_byte[3:0];
          tick_wait = 16'd1;
        end
        3'd2, 3'd6: begin
          pins[PIN_E] = 1'b1;
          tick_wait = 16'd1;
        end
        3'd3: begin
          pins[PIN_E] = 1'b0;
          tick_wait = 16'(nib_settle);
        end
        default: begin
          pins[PIN_E] = 1'b0;
          tick_wait = 16'(nib_settle) + 16'(byte_settle);
          step = STEP_IDLE;
          if (init_bytes) begin
            case (cur_byte[7:0])
              8'h28:   next_cmd = 8'h0C;
              8'h0C:   next_cmd = 8'h06;
              8'h06:   next_cmd = 8'h01;
              default: next_cmd = 8'h00;
            endcase
            if (next_cmd == 8'h00) begin
              tick_wait += FINAL_WAIT;
            end else begin
              cur_byte = {1'b0, next_cmd};
              step = STEP_INIT_BYTES;
            end
          end
        end
      endcase
    endfunction

    function void note_input(logic [1:0] op, logic [7:0] value, bit data_flag,
                             logic [7:0] new_budget);
      bit         drop;
      bit         busy;
      logic [4:0] s;
      logic [1:0] k;
      drop = 1'b0;
      case (op)
        OP_ENQUEUE: begin
          if (level >= QUEUE_DEPTH_DEF) begin
            rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH_DEF;
            level--;
            drop = 1'b1;
          end
          fifo_mem[wr_ptr] = {data_flag, value};
          wr_ptr = (wr_ptr + 1) % QUEUE_DEPTH_DEF;
          level++;
        end
        OP_BUDGET: budget_left = new_budget;
        OP_TICK: begin
          if (tick_wait != 16'd0) tick_wait--;
          if (tick_wait == 16'd0) begin
            s = step;
            if (s == STEP_POWER_UP) begin
              pins = '0;
              tick_wait = POWER_WAIT;
              step = 5'd1;
            end else if (s < STEP_INIT_BYTES) begin
              // power-up nibbles 3,3,3,2: E high for one tick, then the long wait
              k = 2'((s - 5'd1) >> 1);
              if (s[0]) begin
                pins = {(k == 2'd3) ? 4'h2 : 4'h3, 2'b10};
                tick_wait = 16'd1;
              end else begin
                pins[PIN_E] = 1'b0;
                tick_wait = 16'(nib_settle) + ((k == 2'd0) ? 16'd5000 : 16'd1000);
              end
              if (s == STEP_LAST_NIB) cur_byte = FIRST_INIT_BYTE;
              step = s + 5'd1;
            end else if (s < STEP_IDLE) begin
              byte_phase(s);
            end else if (budget_left != 8'd0 && level != 0) begin
              cur_byte = fifo_mem[rd_ptr];
              rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH_DEF;
              level--;
              budget_left--;
              byte_phase(STEP_USER_BYTES);
            end
          end
        end
        default: ;
      endcase
      busy = (step < STEP_IDLE) || (tick_wait != 16'd0);
      expected_q.push_back({init_seen(), busy, drop, 7'(level), pins});
    endfunction

    function void check_result(logic [15:0] got);
      logic [15:0] want;
      bit          bad;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result with nothing pending: %h", got);
        return;
      end
      want = expected_q.pop_front();
      bad = 1'b0;
      if (got[0]     !== want[0])     bad = 1'b1;  // RS
      if (got[1]     !== want[1])     bad = 1'b1;  // E
      if (got[5:2]   !== want[5:2])   bad = 1'b1;  // D4..D7
      if (got[12:6]  !== want[12:6])  bad = 1'b1;  // queue level
      if (got[13]    !== want[13])    bad = 1'b1;  // dropped
      if (got[14]    !== want[14])    bad = 1'b1;  // busy
      if (got[15]    !== want[15])    bad = 1'b1;  // init done
      if (bad) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch exp rs=%b e=%b d=%h lvl=%0d drop=%b busy=%b init=%b",
                    " | got rs=%b e=%b d=%h lvl=%0d drop=%b busy=%b init=%b"},
                   want[0], want[1], want[5:2], want[12:6], want[13], want[14], want[15],
                   got[0], got[1], got[5:2], got[12:6], got[13], got[14], got[15]);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [9:0]  cfg_data = '0;

  // Percent of cycles the sender idles and the receiver stalls
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  lcd_scoreboard sb = new();

  char_lcd_nibble_writer_fifo_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Offer one item, idling first at the current rate; note it once accepted.
  // Leave tvalid high afterward so back-to-back items never toggle it.
  task automatic send_item(input logic [1:0] op, input logic [7:0] value,
                           input bit flag, input logic [7:0] bud);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {bud, value};
    in_tuser  <= {flag, op};
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, value, flag, bud);
  endtask

  // Random payload for a given operation
  task automatic send_op(input logic [1:0] op);
    send_item(op, 8'($urandom), 1'($urandom), 8'($urandom));
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_config(idx, val);
  endtask

  // Drop tvalid and hold until every predicted result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One phase of random traffic at a fixed register setting and idle pattern
  task automatic run_phase(input logic [7:0] nib, input logic [9:0] bset,
                           input int unsigned idle_pct, input int unsigned stall_pct,
                           input int unsigned n_items, input int unsigned tick_hint);
    int unsigned sent, n, pick, i, ticks;
    logic [7:0]  bud;
    drain_results();
    write_reg(CFG_NIBBLE_SETTLE, 10'(nib));
    write_reg(CFG_BYTE_SETTLE, bset);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (sent == 0 || pick < 8) begin
        // Overrun the queue so the oldest bytes get dropped
        n = $urandom_range(QUEUE_DEPTH_DEF + 8, QUEUE_DEPTH_DEF);
        for (i = 0; i < n; i++) send_op(OP_ENQUEUE);
        sent += n;
      end else if (pick < 75) begin
        // Queue a few bytes, grant a budget, then let time run
        n = $urandom_range(6, 1);
        for (i = 0; i < n; i++) send_op(OP_ENQUEUE);
        case ($urandom_range(7))
          0:       bud = 8'd0;
          1:       bud = 8'd255;
          2:       bud = 8'($urandom);
          3:       bud = 8'(n - 1);
          default: bud = 8'(n);
        endcase
        send_item(OP_BUDGET, 8'($urandom), 1'($urandom), bud);
        ticks = $urandom_range(tick_hint, 4);
        for (i = 0; i < ticks; i++) begin
          // Slip an enqueue or a new budget in mid-transfer now and then
          pick = $urandom_range(99);
          if (pick < 4) send_op(OP_ENQUEUE);
          else if (pick < 6) send_op(OP_BUDGET);
          else send_op(OP_TICK);
        end
        sent += n + 1 + ticks;
      end else begin
        // Noise: any operation, the unused code included
        n = $urandom_range(10, 1);
        for (i = 0; i < n; i++) send_op(2'($urandom));
        sent += n;
      end
    end
  endtask

  // Receiver: check every accepted result, stall at the current rate
  initial begin
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: unused operation at both extremes, byte and flag extremes,
    // budget extremes, the first tick that opens the power-up wait, and an
    // enqueue while power-up is still running. Registers stay at reset values.
    send_item(OP_UNUSED, 8'hFF, 1'b1, 8'hFF);
    send_item(OP_UNUSED, 8'h00, 1'b0, 8'h00);
    send_item(OP_ENQUEUE, 8'h00, 1'b0, 8'hFF);
    send_item(OP_ENQUEUE, 8'hFF, 1'b1, 8'h00);
    send_item(OP_ENQUEUE, 8'h5A, 1'b0, 8'hA5);
    send_item(OP_ENQUEUE, 8'hA5, 1'b1, 8'h5A);
    send_item(OP_BUDGET, 8'hFF, 1'b1, 8'd0);
    send_item(OP_BUDGET, 8'h00, 1'b0, 8'd255);
    send_item(OP_BUDGET, 8'h3C, 1'b0, 8'd3);
    send_item(OP_TICK, 8'h00, 1'b0, 8'h00);
    send_item(OP_TICK, 8'hFF, 1'b1, 8'hFF);
    send_item(OP_ENQUEUE, 8'h80, 1'b1, 8'h01);

    // Run the power-up sequence through, then long enough to send the
    // bytes granted above at the reset settle times
    while (!sb.init_seen()) send_op(OP_TICK);
    repeat (3000) send_op(OP_TICK);

    // Random phases: zero settle (acts as one tick), both maxima, and two
    // small settings, each with its own idle pattern
    run_phase(8'd0,   10'd0,    0,  0,  220,  80);
    run_phase(8'd255, 10'd1023, 0,  69, 400,  1400);
    run_phase(8'd2,   10'd5,    69, 0,  250,  120);
    run_phase(8'd1,   10'd0,    38, 38, 260,  80);

    drain_results();
    repeat (16) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("[char_lcd_nibble_writer_fifo_unit] OK");
    end else begin
      $display("[char_lcd_nibble_writer_fifo_unit] ERROR");
    end
    $finish;
  end

  // Watchdog: many times the slowest correct run
  initial begin
    #(8 * 3000000);
    $display("[char_lcd_nibble_writer_fifo_unit] ERROR");
    $finish;
  end

endmodule

### filelist.f
sv/clnw_pkg.sv
sv/clnw_seq.sv
sv/char_lcd_nibble_writer_fifo_unit.sv
test/testbench.sv
